[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[src/hapu_pkg.sv]
// types and constants of the sound register sequencer
`timescale 1ns / 1ps
package hapu_pkg;
    localparam logic [10:0] MAX_FREQ = 11'd2047;
    localparam logic [5:0]  ADDR_LIMIT = 6'h30;

    localparam logic [5:0] A_SQ1_SWEEP = 6'h00;
    localparam logic [5:0] A_SQ1_LEN   = 6'h01;
    localparam logic [5:0] A_SQ1_ENV   = 6'h02;
    localparam logic [5:0] A_SQ1_FLO   = 6'h03;
    localparam logic [5:0] A_SQ1_FHI   = 6'h04;
    localparam logic [5:0] A_SQ2_SWEEP = 6'h05;
    localparam logic [5:0] A_SQ2_LEN   = 6'h06;
    localparam logic [5:0] A_SQ2_ENV   = 6'h07;
    localparam logic [5:0] A_SQ2_FLO   = 6'h08;
    localparam logic [5:0] A_SQ2_FHI   = 6'h09;
    localparam logic [5:0] A_WAVE_LEN  = 6'h0b;
    localparam logic [5:0] A_WAVE_LVL  = 6'h0c;
    localparam logic [5:0] A_WAVE_FLO  = 6'h0d;
    localparam logic [5:0] A_WAVE_FHI  = 6'h0e;
    localparam logic [5:0] A_NOI_LEN   = 6'h10;
    localparam logic [5:0] A_NOI_ENV   = 6'h11;
    localparam logic [5:0] A_NOI_POLY  = 6'h12;
    localparam logic [5:0] A_NOI_TRIG  = 6'h13;
    localparam logic [5:0] A_PAN       = 6'h15;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  reg_addr;
        logic [7:0]  reg_data;
    } req_t;

    typedef struct packed {
        logic [3:0]  chan_enabled;
        logic [3:0]  sq1_volume;
        logic [3:0]  sq2_volume;
        logic [3:0]  noise_volume;
        logic [1:0]  wave_level_code;
        logic [7:0]  pan_bits;
        logic [13:0] sq1_period;
        logic [13:0] sq2_period;
        logic [12:0] wave_period;
        logic [21:0] noise_period;
        logic        noise_short_mode;
        logic [10:0] sq1_swept_freq;
    } rsp_t;

    typedef struct packed {
        logic [3:0] value;
        logic [3:0] start;
        logic       up;
        logic [3:0] count;
        logic [2:0] reload;
        logic       active;
    } env_t;

    function automatic logic [6:0] noise_divisor(input logic [2:0] sel);
        logic [6:0] r;
        case (sel)
            3'd0: r = 7'd8;
            3'd1: r = 7'd16;
            3'd2: r = 7'd32;
            3'd3: r = 7'd48;
            3'd4: r = 7'd64;
            3'd5: r = 7'd80;
            3'd6: r = 7'd96;
            default: r = 7'd112;
        endcase
        return r;
    endfunction

    // one envelope clock
    function automatic env_t env_clock(input env_t e);
        env_t r;
        r = e;
        if (e.count > 4'd1)
        begin
            r.count = e.count - 4'd1;
        end
        else
        begin
            r.count = (e.reload != 3'd0) ? {1'b0, e.reload} : 4'd8;
            if (e.active && e.reload != 3'd0)
            begin
                if (e.up && e.value != 4'd15)
                    r.value = e.value + 4'd1;
                else if (!e.up && e.value != 4'd0)
                    r.value = e.value - 4'd1;
            end
            if (r.value == 4'd0 || r.value == 4'd15)
                r.active = 1'b0;
        end
        return r;
    endfunction

    function automatic env_t env_load(input env_t e, input logic [7:0] d);
        env_t r;
        r = e;
        r.start = d[7:4];
        r.value = d[7:4];
        r.up = d[3];
        r.reload = d[2:0];
        r.count = {1'b0, d[2:0]};
        return r;
    endfunction

    function automatic env_t env_trig(input env_t e);
        env_t r;
        r = e;
        r.active = 1'b1;
        r.count = {1'b0, e.reload};
        r.value = e.start;
        return r;
    endfunction

    // swept frequency, 12 bits so overflow shows in the top bit
    function automatic logic [11:0] sweep_calc(input logic [10:0] sh, input logic [2:0] s,
                                               input logic down);
        logic [10:0] delta;
        delta = sh >> s;
        return down ? ({1'b0, sh} - {1'b0, delta}) : ({1'b0, sh} + {1'b0, delta});
    endfunction
endpackage

[src/hapu_if.sv]
// valid/ready channel carrying one word of type T
`timescale 1ns / 1ps
interface hapu_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/handheld_apu_register_sequencer_core.sv]
// Latency: a word accepted at one edge has its result registered at the same edge, shown
// the next cycle. Throughput: one word per cycle; the output register accepts a new word
// whenever it is empty or being taken. The state update is one pass of logic per word.
// Reset: asynchronous active-low, all channel state and the output valid cleared to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module handheld_apu_register_sequencer_core
    import hapu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hapu_if.sink   req,
    hapu_if.source rsp
);
    logic [2:0]  sw_shift_reg [2], sw_shift_next [2];
    logic        sw_down_reg [2], sw_down_next [2];
    logic [2:0]  sw_reload_reg [2], sw_reload_next [2];
    logic [3:0]  sw_count_reg [2], sw_count_next [2];
    logic [10:0] sw_shadow_reg [2], sw_shadow_next [2];
    logic        sw_on_reg [2], sw_on_next [2];
    logic [10:0] freq_reg [2], freq_next [2];
    logic [13:0] period_reg [2], period_next [2];
    logic [8:0]  len_reg [4], len_next [4];
    logic [3:0]  len_on_reg, len_on_next;
    env_t        env_reg [3], env_next [3];
    logic [3:0]  on_reg, on_next;
    logic [10:0] wfreq_reg, wfreq_next;
    logic [12:0] wtimer_reg, wtimer_next;
    logic [1:0]  wlevel_reg, wlevel_next;
    logic [2:0]  ndiv_reg, ndiv_next;
    logic [3:0]  nshift_reg, nshift_next;
    logic        nshort_reg, nshort_next;
    logic [21:0] ntimer_reg, ntimer_next;
    logic [7:0]  pan_reg, pan_next;
    logic        out_valid_reg;
    rsp_t        out_reg, out_next;
    logic        take;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign take = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    always_comb
    begin
        logic [7:0]  d;
        logic [5:0]  a;
        logic [11:0] nf;
        logic [11:0] nf2;
        int q;
        d = req.data.reg_data;
        a = req.data.reg_addr;
        sw_shift_next = sw_shift_reg;
        sw_down_next = sw_down_reg;
        sw_reload_next = sw_reload_reg;
        sw_count_next = sw_count_reg;
        sw_shadow_next = sw_shadow_reg;
        sw_on_next = sw_on_reg;
        freq_next = freq_reg;
        period_next = period_reg;
        len_next = len_reg;
        len_on_next = len_on_reg;
        env_next = env_reg;
        on_next = on_reg;
        wfreq_next = wfreq_reg;
        wtimer_next = wtimer_reg;
        wlevel_next = wlevel_reg;
        ndiv_next = ndiv_reg;
        nshift_next = nshift_reg;
        nshort_next = nshort_reg;
        ntimer_next = ntimer_reg;
        pan_next = pan_reg;
        nf = '0;
        nf2 = '0;
        q = 0;
        if (req.data.req_type == REQ_TICK)
        begin
            // steps 0..7: length at even steps, sweep at 2 and 6, envelope at 7
            for (int step = 0; step < 8; step++)
            begin
                if ((step % 2) == 0)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        if (len_on_next[c])
                        begin
                            if (len_next[c] != 9'd0)
                            begin
                                len_next[c] = len_next[c] - 9'd1;
                                if (len_next[c] == 9'd0)
                                    on_next[c] = 1'b0;
                            end
                            else
                                on_next[c] = 1'b0;
                        end
                    end
                    if (step == 2 || step == 6)
                    begin
                        if (sw_count_next[0] > 4'd1)
                            sw_count_next[0] = sw_count_next[0] - 4'd1;
                        else
                        begin
                            sw_count_next[0] = (sw_reload_next[0] != 3'd0) ?
                                {1'b0, sw_reload_next[0]} : 4'd8;
                            if (sw_on_next[0] && sw_reload_next[0] != 3'd0)
                            begin
                                nf = sweep_calc(sw_shadow_next[0], sw_shift_next[0],
                                                sw_down_next[0]);
                                if (nf[11])
                                    on_next[0] = 1'b0;
                                else if (sw_shift_next[0] != 3'd0)
                                begin
                                    sw_shadow_next[0] = nf[10:0];
                                    freq_next[0] = nf[10:0];
                                    nf2 = sweep_calc(nf[10:0], sw_shift_next[0],
                                                     sw_down_next[0]);
                                    if (nf2[11])
                                        on_next[0] = 1'b0;
                                end
                            end
                        end
                    end
                end
                else if (step == 7)
                begin
                    for (int e = 0; e < 3; e++)
                        env_next[e] = env_clock(env_next[e]);
                end
            end
        end
        else if (a < ADDR_LIMIT)
        begin
            if (a <= A_SQ2_FHI)
            begin
                q = (a >= A_SQ2_SWEEP) ? 1 : 0;
                case ((a >= A_SQ2_SWEEP) ? a - A_SQ2_SWEEP : a)
                    A_SQ1_SWEEP:
                    begin
                        sw_shift_next[q] = d[2:0];
                        sw_down_next[q] = d[3];
                        sw_reload_next[q] = d[6:4];
                    end
                    A_SQ1_LEN: len_next[q] = 9'd64 - {3'd0, d[5:0]};
                    A_SQ1_ENV: env_next[q] = env_load(env_reg[q], d);
                    A_SQ1_FLO:
                    begin
                        freq_next[q] = {freq_reg[q][10:8], d};
                        period_next[q] = {12'd2048 - {1'b0, freq_next[q]}, 2'b00};
                    end
                    default:
                    begin
                        freq_next[q] = {d[2:0], freq_reg[q][7:0]};
                        period_next[q] = {12'd2048 - {1'b0, freq_next[q]}, 2'b00};
                        len_on_next[q] = d[6];
                        if (d[7])
                        begin
                            on_next[q] = 1'b1;
                            if (len_reg[q] == 9'd0)
                                len_next[q] = 9'd64;
                            env_next[q] = env_trig(env_reg[q]);
                            sw_shadow_next[q] = freq_next[q];
                            sw_count_next[q] = (sw_reload_reg[q] != 3'd0) ?
                                {1'b0, sw_reload_reg[q]} : 4'd8;
                            sw_on_next[q] = (sw_reload_reg[q] != 3'd0) ||
                                            (sw_shift_reg[q] != 3'd0);
                            if (sw_shift_reg[q] != 3'd0)
                            begin
                                nf = sweep_calc(freq_next[q], sw_shift_reg[q],
                                                sw_down_reg[q]);
                                if (nf[11])
                                    on_next[q] = 1'b0;
                            end
                        end
                    end
                endcase
            end
            else
            begin
                case (a)
                    A_WAVE_LEN: len_next[2] = 9'd256 - {1'b0, d};
                    A_WAVE_LVL: wlevel_next = d[6:5];
                    A_WAVE_FLO: wfreq_next = {wfreq_reg[10:8], d};
                    A_WAVE_FHI:
                    begin
                        wfreq_next = {d[2:0], wfreq_reg[7:0]};
                        wtimer_next = {12'd2048 - {1'b0, wfreq_next}, 1'b0};
                        len_on_next[2] = d[6];
                        if (d[7])
                        begin
                            on_next[2] = 1'b1;
                            if (len_reg[2] == 9'd0)
                                len_next[2] = 9'd256;
                        end
                    end
                    A_NOI_LEN: len_next[3] = 9'd64 - {3'd0, d[5:0]};
                    A_NOI_ENV: env_next[2] = env_load(env_reg[2], d);
                    A_NOI_POLY:
                    begin
                        ndiv_next = d[2:0];
                        nshort_next = d[3];
                        nshift_next = d[7:4];
                    end
                    A_NOI_TRIG:
                    begin
                        len_on_next[3] = d[6];
                        if (d[7])
                        begin
                            on_next[3] = 1'b1;
                            if (len_reg[3] == 9'd0)
                                len_next[3] = 9'd64;
                            ntimer_next = {15'd0, noise_divisor(ndiv_reg)} << nshift_reg;
                            env_next[2] = env_trig(env_reg[2]);
                        end
                    end
                    A_PAN: pan_next = d;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        out_next.chan_enabled = on_next;
        out_next.sq1_volume = env_next[0].value;
        out_next.sq2_volume = env_next[1].value;
        out_next.noise_volume = env_next[2].value;
        out_next.wave_level_code = wlevel_next;
        out_next.pan_bits = pan_next;
        out_next.sq1_period = period_next[0];
        out_next.sq2_period = period_next[1];
        out_next.wave_period = wtimer_next;
        out_next.noise_period = ntimer_next;
        out_next.noise_short_mode = nshort_next;
        out_next.sq1_swept_freq = freq_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sw_shift_reg[i] <= '0;
                sw_down_reg[i] <= '0;
                sw_reload_reg[i] <= '0;
                sw_count_reg[i] <= '0;
                sw_shadow_reg[i] <= '0;
                sw_on_reg[i] <= '0;
                freq_reg[i] <= '0;
                period_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
                len_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                env_reg[i] <= '0;
            len_on_reg <= '0;
            on_reg <= '0;
            wfreq_reg <= '0;
            wtimer_reg <= '0;
            wlevel_reg <= '0;
            ndiv_reg <= '0;
            nshift_reg <= '0;
            nshort_reg <= '0;
            ntimer_reg <= '0;
            pan_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                sw_shift_reg <= sw_shift_next;
                sw_down_reg <= sw_down_next;
                sw_reload_reg <= sw_reload_next;
                sw_count_reg <= sw_count_next;
                sw_shadow_reg <= sw_shadow_next;
                sw_on_reg <= sw_on_next;
                freq_reg <= freq_next;
                period_reg <= period_next;
                len_reg <= len_next;
                len_on_reg <= len_on_next;
                env_reg <= env_next;
                on_reg <= on_next;
                wfreq_reg <= wfreq_next;
                wtimer_reg <= wtimer_next;
                wlevel_reg <= wlevel_next;
                ndiv_reg <= ndiv_next;
                nshift_reg <= nshift_next;
                nshort_reg <= nshort_next;
                ntimer_reg <= ntimer_next;
                pan_reg <= pan_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    `ASSERT_IMPLIES(a_ready_when_free, clk, rst_n, !out_valid_reg, req.ready)
    `ASSERT_NEXT(a_take_gives_word, clk, rst_n, take, rsp.valid)
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, rsp.valid && !rsp.ready, $stable(rsp.data))
    `ASSERT_NEXT(a_state_holds, clk, rst_n, !take, $stable(on_reg) && $stable(pan_reg))
endmodule
